FILE: src/aavr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared constants, types and the CORDIC arctangent table for the rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 14;
  localparam int CF_BITS       = 30;
  localparam int CW            = 34;  // CORDIC x/y width
  localparam int ZW            = 34;  // CORDIC angle accumulator width
  localparam int STW           = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Data carried alongside the CORDIC through the row of cells
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } side_t;

  typedef struct packed {
    logic                 vld;
    logic                 neg;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      0: r = ZW'(536870912);  1: r = ZW'(316933406);  2: r = ZW'(167458907);
      3: r = ZW'(85004756);   4: r = ZW'(42667331);   5: r = ZW'(21354465);
      6: r = ZW'(10679838);   7: r = ZW'(5340245);    8: r = ZW'(2670163);
      9: r = ZW'(1335087);   10: r = ZW'(667544);    11: r = ZW'(333772);
     12: r = ZW'(166886);    13: r = ZW'(83443);     14: r = ZW'(41722);
     15: r = ZW'(20861);     16: r = ZW'(10430);     17: r = ZW'(5215);
     18: r = ZW'(2608);      19: r = ZW'(1304);      20: r = ZW'(652);
     21: r = ZW'(326);       22: r = ZW'(163);       23: r = ZW'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round half up, drop FRAC_BITS bits
  function automatic logic signed [47:0] rnd_f(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + (48'sd1 <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

FILE: src/aavr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_cell
// One CORDIC rotation cell: a single micro-rotation, registered.
// ----------------------------------------------------------------------------
module aavr_cell
  import aavr_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic [STW-1:0] idx,   // position in the row, tied off
  input  wire cell_t          din,
  output cell_t               dout
);

  cell_t nxt;

  // Rotate toward zero residual angle; no table entry past 23
  always_comb begin
    nxt = din;
    if (int'(idx) < 24) begin
      if (!din.z[ZW-1]) begin
        nxt.x = din.x - (din.y >>> idx);
        nxt.y = din.y + (din.x >>> idx);
        nxt.z = din.z - atan_turn(int'(idx));
      end else begin
        nxt.x = din.x + (din.y >>> idx);
        nxt.y = din.y - (din.x >>> idx);
        nxt.z = din.z + atan_turn(int'(idx));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.neg  <= nxt.neg;
      dout.x    <= nxt.x;
      dout.y    <= nxt.y;
      dout.z    <= nxt.z;
      dout.side <= nxt.side;
    end
  end

endmodule
`default_nettype wire

FILE: src/aavr_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_matrix
// Rodrigues matrix build and vector multiply, pipelined, with the multiplies
// in stages 2 to 4, then round and saturate.
// ----------------------------------------------------------------------------
module aavr_matrix
  import aavr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire cell_t       din,
  output logic             vld,
  output logic [17:0]      rx,
  output logic [17:0]      ry,
  output logic [17:0]      rz,
  output logic             sat
);

  localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;

  // Stage 1: final sin/cos
  logic signed [47:0] c0, s0, cx, sy;
  always_comb begin
    cx = din.neg ? -48'(din.x) : 48'(din.x);
    sy = din.neg ? -48'(din.y) : 48'(din.y);
    c0 = (cx + (48'sd1 <<< (CF_BITS - FRAC_BITS - 1))) >>> (CF_BITS - FRAC_BITS);
    s0 = (sy + (48'sd1 <<< (CF_BITS - FRAC_BITS - 1))) >>> (CF_BITS - FRAC_BITS);
    if (c0 > ONE) c0 = ONE;
    if (c0 < -ONE) c0 = -ONE;
    if (s0 > ONE) s0 = ONE;
    if (s0 < -ONE) s0 = -ONE;
  end

  logic               v1, v2, v3, v4, v5;
  logic signed [17:0] c1, s1, c2;
  side_t              sd1, sd2, sd3;
  logic signed [17:0] omc2;
  logic signed [17:0] xx, yy, zz, xy, yz, zx, xs, ys, zs;
  logic signed [31:0] pa [9];   // axis products, full precision
  logic signed [35:0] pm [6];   // (1 - C) times axis products
  logic signed [19:0] m [9];
  logic signed [35:0] p [9];

  // Stage 2 products: axis pairs and axis times sine
  always_comb begin
    pa[0] = sd1.ax * sd1.ax;
    pa[1] = sd1.ay * sd1.ay;
    pa[2] = sd1.az * sd1.az;
    pa[3] = sd1.ax * sd1.ay;
    pa[4] = sd1.ay * sd1.az;
    pa[5] = sd1.az * sd1.ax;
    pa[6] = sd1.ax * s1;
    pa[7] = sd1.ay * s1;
    pa[8] = sd1.az * s1;
  end

  // Stage 3 products: one minus cosine times axis pairs
  always_comb begin
    pm[0] = omc2 * xx;
    pm[1] = omc2 * yy;
    pm[2] = omc2 * zz;
    pm[3] = omc2 * xy;
    pm[4] = omc2 * yz;
    pm[5] = omc2 * zx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v1 <= din.vld; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
    if (en) begin
      // stage 1
      c1  <= 18'(c0);
      s1  <= 18'(s0);
      sd1 <= din.side;
      // stage 2: axis products
      xx <= 18'(rnd_f(48'(pa[0])));
      yy <= 18'(rnd_f(48'(pa[1])));
      zz <= 18'(rnd_f(48'(pa[2])));
      xy <= 18'(rnd_f(48'(pa[3])));
      yz <= 18'(rnd_f(48'(pa[4])));
      zx <= 18'(rnd_f(48'(pa[5])));
      xs <= 18'(rnd_f(48'(pa[6])));
      ys <= 18'(rnd_f(48'(pa[7])));
      zs <= 18'(rnd_f(48'(pa[8])));
      omc2 <= 18'(ONE - 48'(c1));
      c2  <= c1;
      sd2 <= sd1;
      // stage 3: matrix entries
      m[0] <= 20'(rnd_f(48'(pm[0])) + 48'(c2));
      m[1] <= 20'(rnd_f(48'(pm[3])) - 48'(zs));
      m[2] <= 20'(rnd_f(48'(pm[5])) + 48'(ys));
      m[3] <= 20'(rnd_f(48'(pm[3])) + 48'(zs));
      m[4] <= 20'(rnd_f(48'(pm[1])) + 48'(c2));
      m[5] <= 20'(rnd_f(48'(pm[4])) - 48'(xs));
      m[6] <= 20'(rnd_f(48'(pm[5])) - 48'(ys));
      m[7] <= 20'(rnd_f(48'(pm[4])) + 48'(xs));
      m[8] <= 20'(rnd_f(48'(pm[2])) + 48'(c2));
      sd3 <= sd2;
      // stage 4: entry times component
      p[0] <= m[0] * sd3.vx; p[1] <= m[1] * sd3.vy; p[2] <= m[2] * sd3.vz;
      p[3] <= m[3] * sd3.vx; p[4] <= m[4] * sd3.vy; p[5] <= m[5] * sd3.vz;
      p[6] <= m[6] * sd3.vx; p[7] <= m[7] * sd3.vy; p[8] <= m[8] * sd3.vz;
    end
  end

  // Stage 5: sum, round, saturate
  logic signed [47:0] acc [3];
  logic [17:0]        r_n [3];
  logic [2:0]         s_n;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = rnd_f(48'(p[3*k]) + 48'(p[3*k+1]) + 48'(p[3*k+2]));
      s_n[k] = 1'b0;
      r_n[k] = 18'(acc[k]);
      if (acc[k] > 48'(OUT_MAX)) begin
        r_n[k] = 18'(OUT_MAX);
        s_n[k] = 1'b1;
      end
      if (acc[k] < 48'(OUT_MIN)) begin
        r_n[k] = 18'(OUT_MIN);
        s_n[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx  <= r_n[0];
      ry  <= r_n[1];
      rz  <= r_n[2];
      sat <= |s_n;
    end
  end
  assign vld = v5;

endmodule
`default_nettype wire

FILE: src/axis_angle_vector_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// Rotates a vector about a unit axis by a binary angle (Rodrigues matrix).
// ----------------------------------------------------------------------------
// Fully pipelined: one word accepted per clock unless the output stalls. The
// path is one input register, one CORDIC cell per stage, five matrix stages.
// The whole pipeline advances whenever the output register is empty or being
// taken, so downstream stalls hold every stage in place.
module axis_angle_vector_rotate
  import aavr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // angle[15:0], axis_x[31:16], axis_y[47:32], axis_z[63:48],
  // vec_x[79:64], vec_y[95:80], vec_z[111:96]
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rot_x[17:0], rot_y[35:18], rot_z[53:36], saturated[54], zero[55]
  output logic [55:0]       m_axis_tdata
);

  logic  en;
  cell_t chain [CORDIC_STAGES+1];
  cell_t head;
  cell_t in_q;
  logic [31:0] a32;
  logic        neg;
  logic  mv;
  logic [17:0] rx, ry, rz;
  logic        sat;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Quadrant fold and CORDIC seed
  always_comb begin
    a32 = {s_axis_tdata[15:0], 16'h0};
    neg = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
    if (neg) a32 = a32 - 32'h8000_0000;
    head.vld = s_axis_tvalid;
    head.neg = neg;
    head.x   = CORDIC_GAIN;
    head.y   = '0;
    head.z   = ZW'($signed(a32));
    head.side.ax = s_axis_tdata[31:16];
    head.side.ay = s_axis_tdata[47:32];
    head.side.az = s_axis_tdata[63:48];
    head.side.vx = s_axis_tdata[79:64];
    head.side.vy = s_axis_tdata[95:80];
    head.side.vz = s_axis_tdata[111:96];
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q.vld <= 1'b0;
    end else if (en) begin
      in_q.vld <= head.vld;
    end
    if (en) begin
      in_q.neg  <= head.neg;
      in_q.x    <= head.x;
      in_q.y    <= head.y;
      in_q.z    <= head.z;
      in_q.side <= head.side;
    end
  end
  assign chain[0] = in_q;

  // Row of CORDIC cells
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    aavr_cell u_cell (
      .clk (clk), .rst (rst), .en (en), .idx (STW'(g)),
      .din (chain[g]), .dout (chain[g+1])
    );
  end

  aavr_matrix u_mat (
    .clk (clk), .rst (rst), .en (en), .din (chain[CORDIC_STAGES]),
    .vld (mv), .rx (rx), .ry (ry), .rz (rz), .sat (sat)
  );

  assign m_axis_tvalid = mv;
  assign m_axis_tdata  = {1'b0, sat, rz, ry, rx};

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream regression for the axis-angle vector rotator. Words are sent with
// random burst/gap pacing and checked against a bit-exact Rodrigues predictor
// (CORDIC sine/cosine, fixed-point matrix, saturation) run in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import aavr_pkg::*;

  typedef struct packed {
    logic        sat;
    logic [17:0] rz;
    logic [17:0] ry;
    logic [17:0] rx;
  } rot_word_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;

  rot_word_t rot_expected[$];
  int        errors;
  int        idle_cycles;
  bit        hold_off;

  localparam int WATCHDOG = 20000;
  localparam int LATENCY  = CORDIC_STAGES + 6;

  axis_angle_vector_rotate dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor helpers
  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unit_clamp(longint v);
    longint one;
    one = 64'sd1 <<< FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_sh(a * b, FRAC_BITS);
  endfunction

  // Returns {clipped, value}
  function automatic logic [18:0] clip_out(longint acc);
    longint v;
    logic   clipped;
    clipped = 1'b0;
    v = round_sh(acc, FRAC_BITS);
    if (v > OUT_MAX) begin v = OUT_MAX; clipped = 1'b1; end
    if (v < OUT_MIN) begin v = OUT_MIN; clipped = 1'b1; end
    return {clipped, v[17:0]};
  endfunction

  function automatic longint atan_entry(int i);
    longint t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic rot_word_t rotate_vector(logic [111:0] w);
    logic [31:0] turn;
    bit          flip;
    logic [18:0] cx, cy, cz;
    longint      x, y, z, nx, s, c, omc;
    longint      ax, ay, az, vx, vy, vz;
    longint      xx, yy, zz, xy, yz, zx, xs, ys, zs;
    longint      m00, m01, m02, m10, m11, m12, m20, m21, m22;
    rot_word_t   r;
    turn = {w[15:0], 16'h0};
    flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
    if (flip) turn = turn - 32'h8000_0000;
    z = longint'($signed(turn));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_sh(y, i);
        y  = y + floor_sh(x, i);
        z  = z - atan_entry(i);
      end else begin
        nx = x + floor_sh(y, i);
        y  = y - floor_sh(x, i);
        z  = z + atan_entry(i);
      end
      x = nx;
    end
    if (flip) begin x = -x; y = -y; end
    c = unit_clamp(round_sh(x, CF_BITS - FRAC_BITS));
    s = unit_clamp(round_sh(y, CF_BITS - FRAC_BITS));
    omc = (64'sd1 <<< FRAC_BITS) - c;
    ax = $signed(w[31:16]);  ay = $signed(w[47:32]);  az = $signed(w[63:48]);
    vx = $signed(w[79:64]);  vy = $signed(w[95:80]);  vz = $signed(w[111:96]);
    xx = qmul(ax, ax); yy = qmul(ay, ay); zz = qmul(az, az);
    xy = qmul(ax, ay); yz = qmul(ay, az); zx = qmul(az, ax);
    xs = qmul(ax, s);  ys = qmul(ay, s);  zs = qmul(az, s);
    m00 = qmul(omc, xx) + c;  m01 = qmul(omc, xy) - zs; m02 = qmul(omc, zx) + ys;
    m10 = qmul(omc, xy) + zs; m11 = qmul(omc, yy) + c;  m12 = qmul(omc, yz) - xs;
    m20 = qmul(omc, zx) - ys; m21 = qmul(omc, yz) + xs; m22 = qmul(omc, zz) + c;
    cx = clip_out(m00 * vx + m01 * vy + m02 * vz);
    cy = clip_out(m10 * vx + m11 * vy + m12 * vz);
    cz = clip_out(m20 * vx + m21 * vy + m22 * vz);
    r.rx = cx[17:0];
    r.ry = cy[17:0];
    r.rz = cz[17:0];
    r.sat = cx[18] | cy[18] | cz[18];
    return r;
  endfunction

  // Send one word; optional gap first, then hold valid until taken
  task automatic send_word(logic [111:0] w, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
    rot_expected.push_back(rotate_vector(w));
  endtask

  task automatic send_fields(logic [15:0] ang, logic [15:0] axx, logic [15:0] axy,
                             logic [15:0] axz, logic [15:0] vx, logic [15:0] vy,
                             logic [15:0] vz, int gap);
    send_word({vz, vy, vx, axz, axy, axx, ang}, gap);
  endtask

  task automatic finish_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  // Random axis: unit-ish along principal or diagonal directions, else raw random components
  function automatic logic [47:0] pick_axis();
    logic [15:0] a [3];
    int k;
    k = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) a[i] = 16'h0;
    case (k)
      0: a[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      1: for (int i = 0; i < 3; i++) a[i] = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
      2: begin
        a[0] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
        a[1] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
      end
      default: for (int i = 0; i < 3; i++) a[i] = 16'($urandom_range(0, 16'hffff));
    endcase
    return {a[2], a[1], a[0]};
  endfunction

  task automatic test_directed();
    logic [15:0] ang [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                             16'h3fff, 16'h7fff, 16'hbfff, 16'hffff};
    foreach (ang[i])
      send_fields(ang[i], 16'sd16384, 16'h0, 16'h0, 16'sd16384, 16'sd8192,
                  -16'sd4096, 0);
    send_fields(16'h2000, 16'h0, 16'h0, 16'sd16384, 16'h7fff, 16'h8000, 16'h7fff, 0);
    send_fields(16'h1000, 16'h0, 16'sd16384, 16'h0, 16'h8000, 16'h8000, 16'h8000, 1);
    // Non-unit axis, extremes: drives saturation both ways
    send_fields(16'h6000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_fields(16'ha000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
    send_fields(16'h4000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_fields(16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 0);
    send_fields(16'h5555, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0001, 16'h0000, 0);
    send_fields(16'haaaa, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0, 2);
    finish_burst();
  endtask

  task automatic test_random(int count);
    int left;
    logic [47:0] ax;
    left = 0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) left = $urandom_range(1, 20);
      left--;
      ax = pick_axis();
      send_fields(16'($urandom_range(0, 16'hffff)), ax[15:0], ax[31:16], ax[47:32],
                  16'($urandom_range(0, 16'hffff)), 16'($urandom_range(0, 16'hffff)),
                  16'($urandom_range(0, 16'hffff)),
                  (left == 0 && $urandom_range(0, 1)) ? $urandom_range(1, 8) : 0);
    end
    finish_burst();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY + 40) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(80);
    join
  endtask

  // Receiver stall pattern
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_axis_tready <= 1'b0;
      else if ($time % 4000 < 1500) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker and watchdog
  initial begin
    rot_word_t exp_w, got;
    errors = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[54:0];
        if (rot_expected.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_w = rot_expected.pop_front();
          if (got.rx !== exp_w.rx || got.ry !== exp_w.ry || got.rz !== exp_w.rz
              || got.sat !== exp_w.sat || m_axis_tdata[55] !== 1'b0) begin
            $display("%0t: mismatch expected rx=%h ry=%h rz=%h sat=%b",
                     $time, exp_w.rx, exp_w.ry, exp_w.rz, exp_w.sat);
            $display("%0t:          actual   rx=%h ry=%h rz=%h sat=%b pad=%b",
                     $time, got.rx, got.ry, got.rz, got.sat, m_axis_tdata[55]);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog timeout", $time);
        $display("axis_angle_vector_rotate regression: fail");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_off = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(520);
    while (rot_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("axis_angle_vector_rotate regression: pass");
    else
      $display("axis_angle_vector_rotate regression: fail");
    $finish;
  end

endmodule
